// File: rtl/cbm_pkg.sv
// Shared types, codes and constants for the cartridge bank mapper.
// No dependencies; imported by every module of the block.
package cbm_pkg;

    localparam int ROM_BANK_BYTES = 16384;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
    localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
    localparam int ROM_BANK_W     = 7;
    localparam int RAM_BANK_W     = 2;
    localparam int LOW_BITS_W     = 5;
    localparam int OFFSET_W       = 21;
    localparam int CODE_W         = 3;
    localparam int CFG_IDX_W      = 1;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // region codes
    localparam logic [1:0] REGION_FIXED_ROM    = 2'd0;
    localparam logic [1:0] REGION_SWITCHED_ROM = 2'd1;
    localparam logic [1:0] REGION_RAM          = 2'd2;
    localparam logic [1:0] REGION_NONE         = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 1'd1;

    // ROM size codes at or above this count as large (over 512 KiB)
    localparam logic [CODE_W-1:0] ROM_CODE_LARGE = 3'd5;
    // RAM size code with exactly one bank
    localparam logic [CODE_W-1:0] RAM_CODE_ONE_BANK = 3'd2;
    localparam logic [CODE_W-1:0] RAM_CODE_MIN      = 3'd2;
    localparam logic [CODE_W-1:0] RAM_CODE_MAX      = 3'd5;

    // enable nibble that turns cartridge RAM on
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef struct packed {
        logic        command;
        logic [15:0] address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] rom_code;
        logic [CODE_W-1:0] ram_code;
    } cfg_t;

    typedef struct packed {
        logic [3:0]            ram_en_nib;
        logic [LOW_BITS_W-1:0] low_bits;
        logic [1:0]            high_bits;
    } bank_state_t;

    typedef struct packed {
        logic [1:0]            region;
        logic [OFFSET_W-1:0]   physical_offset;
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_enabled;
    } result_t;

endpackage

// File: rtl/cbm_ctrl.sv
// Size configuration registers and the bank control registers.
// Gives the bank state as it stands after the current word's write. Uses cbm_pkg.
module cbm_ctrl
    import cbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    input  logic                 advance,
    input  item_t                item,
    output cfg_t                 cfg,
    output bank_state_t          state_view
);

    // address[14:13] of a write below 0x8000
    localparam logic [1:0] SEL_RAM_ENABLE = 2'd0;
    localparam logic [1:0] SEL_LOW_BANK   = 2'd1;
    localparam logic [1:0] SEL_HIGH_BANK  = 2'd2;
    localparam logic [1:0] SEL_MODE       = 2'd3;

    cfg_t        cfg_reg;
    bank_state_t state_reg;

    always_comb
    begin
        state_view = state_reg;
        if (item.command == CMD_WRITE && !item.address[15])
        begin
            case (item.address[14:13])
                SEL_RAM_ENABLE: state_view.ram_en_nib = item.write_data[3:0];
                SEL_LOW_BANK:   state_view.low_bits   = item.write_data[LOW_BITS_W-1:0];
                SEL_HIGH_BANK:  state_view.high_bits  = item.write_data[1:0];
                SEL_MODE:       state_view = state_reg; // mode latch has no effect on mapping
                default:        state_view = state_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            state_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ROM_SIZE: cfg_reg.rom_code <= cfg_data;
                    CFG_RAM_SIZE: cfg_reg.ram_code <= cfg_data;
                    default:      cfg_reg <= cfg_reg;
                endcase
            end
            if (advance)
                state_reg <= state_view;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/cbm_xlate.sv
// Bank resolution and address translation for one bus word.
// Pure logic between the input and result registers. Uses cbm_pkg.
module cbm_xlate
    import cbm_pkg::*;
(
    input  item_t       item,
    input  cfg_t        cfg,
    input  bank_state_t state_view,
    output result_t     res
);

    logic                  large_rom;
    logic                  has_ram;
    logic                  ram_on;
    logic [LOW_BITS_W-1:0] low_eff;
    logic [ROM_BANK_W-1:0] bank_raw;
    logic [7:0]            rom_mask;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;

    always_comb
    begin
        large_rom = (cfg.rom_code >= ROM_CODE_LARGE);
        has_ram   = (cfg.ram_code inside {[RAM_CODE_MIN:RAM_CODE_MAX]});
        ram_on    = (state_view.ram_en_nib == RAM_ENABLE_KEY);
        low_eff   = (state_view.low_bits == '0) ? LOW_BITS_W'(1) : state_view.low_bits;
        bank_raw  = large_rom ? {state_view.high_bits, low_eff}
                              : {2'b00, low_eff};
        // bank count minus one; code 7 wraps to all ones
        rom_mask  = (8'd2 << cfg.rom_code) - 8'd1;
        rom_bank  = bank_raw & rom_mask[ROM_BANK_W-1:0];
        // every nonzero RAM size except one bank has at least four banks
        if (!has_ram || large_rom || cfg.ram_code == RAM_CODE_ONE_BANK)
            ram_bank = '0;
        else
            ram_bank = state_view.high_bits;

        res.region          = REGION_NONE;
        res.physical_offset = '0;
        if (item.command == CMD_READ)
        begin
            if (!item.address[15] && !item.address[14])
            begin
                res.region          = REGION_FIXED_ROM;
                res.physical_offset = {{(OFFSET_W-ROM_OFS_W){1'b0}},
                                       item.address[ROM_OFS_W-1:0]};
            end
            else if (!item.address[15])
            begin
                res.region          = REGION_SWITCHED_ROM;
                res.physical_offset = {rom_bank, item.address[ROM_OFS_W-1:0]};
            end
            else if (item.address[15:13] == 3'b101 && ram_on && has_ram)
            begin
                res.region          = REGION_RAM;
                res.physical_offset = {{(OFFSET_W-RAM_BANK_W-RAM_OFS_W){1'b0}},
                                       ram_bank, item.address[RAM_OFS_W-1:0]};
            end
        end
        res.rom_bank    = rom_bank;
        res.ram_bank    = ram_bank;
        res.ram_enabled = ram_on;
    end

endmodule

// File: rtl/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: input register, result register, handshakes.
// Instantiates cbm_ctrl and cbm_xlate; uses cbm_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  in      | into      | in_valid / in_ready   | command, address, write_data
//  out     | out of    | out_valid / out_ready | region, physical_offset, rom_bank,
//          |           |                       | ram_bank, ram_enabled
//  cfg     | into      | cfg_write             | cfg_index, cfg_data
//
// One word per cycle sustained while out_ready stays high; a taken word goes from the input
// register through the translation logic into the result register.
// Bank registers update as a word moves into the result register, so words see
// the writes of earlier words in order. Reset clears all control and size registers.
// A stalled output holds its result; the input register keeps accepting until it too is full.
module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [15:0]           address,
    input  logic [7:0]            write_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            region,
    output logic [OFFSET_W-1:0]   physical_offset,
    output logic [ROM_BANK_W-1:0] rom_bank,
    output logic [RAM_BANK_W-1:0] ram_bank,
    output logic                  ram_enabled,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CODE_W-1:0]     cfg_data
);

    logic        s1_valid_reg;
    item_t       s1_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_res_reg;
    logic        advance;
    cfg_t        cfg;
    bank_state_t state_view;
    result_t     res;

    assign advance        = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !s1_valid_reg || advance;
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    cbm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .advance    (advance),
        .item       (s1_item_reg),
        .cfg        (cfg),
        .state_view (state_view)
    );

    cbm_xlate u_xlate (
        .item       (s1_item_reg),
        .cfg        (cfg),
        .state_view (state_view),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= '{command: command, address: address, write_data: write_data};
        if (advance)
            out_res_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign region          = out_res_reg.region;
    assign physical_offset = out_res_reg.physical_offset;
    assign rom_bank        = out_res_reg.rom_bank;
    assign ram_bank        = out_res_reg.ram_bank;
    assign ram_enabled     = out_res_reg.ram_enabled;

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");

    a_ram_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && region == REGION_RAM |-> ram_enabled)
        else $error("RAM region given while RAM disabled");

    a_rom_offset_bank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && region == REGION_SWITCHED_ROM
            |-> physical_offset[OFFSET_W-1:ROM_OFS_W] == rom_bank)
        else $error("switched ROM offset does not match ROM bank");

    a_ram_offset_bank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && region == REGION_RAM
            |-> physical_offset[RAM_OFS_W+RAM_BANK_W-1:RAM_OFS_W] == ram_bank)
        else $error("RAM offset does not match RAM bank");

    a_result_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced word did not reach result register");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for cartridge_bank_mapper: directed table, then random bus accesses.
// Depends on cbm_pkg and the cartridge_bank_mapper RTL; every result is checked in order.
`timescale 1ns / 100ps

module testbench;
    import cbm_pkg::*;

    // ROM and RAM size code names not given in the package
    localparam logic [CODE_W-1:0] RAM_CODE_FOUR_BANKS    = 3'd3;
    localparam logic [CODE_W-1:0] RAM_CODE_SIXTEEN_BANKS = 3'd4;
    localparam logic [CODE_W-1:0] RAM_CODE_EIGHT_BANKS   = RAM_CODE_MAX;
    localparam logic [CODE_W-1:0] ROM_CODE_MAX           = 3'd6;
    localparam logic [CODE_W-1:0] ROM_CODE_MIN           = 3'd0;
    localparam logic [CODE_W-1:0] RAM_CODE_NONE          = 3'd0;

    localparam int RANDOM_PHASES    = 12;
    localparam int WORDS_PER_PHASE  = 155;

    typedef enum logic [1:0] {ROW_CONFIG, ROW_CHECKED, ROW_TYPED} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CODE_W-1:0]     reg_value;
        logic                  cmd;
        logic [15:0]           addr;
        logic [7:0]            data;
        result_t               want;
    } row_t;

    localparam result_t NO_RESULT = '0;

    // Starts from reset sizes (ROM code 0, no RAM); typed rows hold for that setting only.
    localparam row_t DIRECTED [29] = '{
        '{ROW_TYPED,   CFG_ROM_SIZE, 3'd0, CMD_READ,  16'h0000, 8'h00,
          '{REGION_FIXED_ROM,    21'h0000, 7'd1, 2'd0, 1'b0}},
        '{ROW_TYPED,   CFG_ROM_SIZE, 3'd0, CMD_READ,  16'h3FFF, 8'h00,
          '{REGION_FIXED_ROM,    21'h3FFF, 7'd1, 2'd0, 1'b0}},
        '{ROW_TYPED,   CFG_ROM_SIZE, 3'd0, CMD_READ,  16'h4000, 8'h00,
          '{REGION_SWITCHED_ROM, 21'h4000, 7'd1, 2'd0, 1'b0}},
        '{ROW_TYPED,   CFG_ROM_SIZE, 3'd0, CMD_READ,  16'h7FFF, 8'h00,
          '{REGION_SWITCHED_ROM, 21'h7FFF, 7'd1, 2'd0, 1'b0}},
        '{ROW_TYPED,   CFG_ROM_SIZE, 3'd0, CMD_READ,  16'h8000, 8'h00,
          '{REGION_NONE,         21'h0000, 7'd1, 2'd0, 1'b0}},
        '{ROW_TYPED,   CFG_ROM_SIZE, 3'd0, CMD_READ,  16'hFFFF, 8'h00,
          '{REGION_NONE,         21'h0000, 7'd1, 2'd0, 1'b0}},
        '{ROW_TYPED,   CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h0000, 8'h0A,
          '{REGION_NONE,         21'h0000, 7'd1, 2'd0, 1'b1}},
        // enabled but no RAM fitted
        '{ROW_TYPED,   CFG_ROM_SIZE, 3'd0, CMD_READ,  16'hA000, 8'h00,
          '{REGION_NONE,         21'h0000, 7'd1, 2'd0, 1'b1}},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h3FFF, 8'hFF, NO_RESULT},
        // low bits 2 on a two-bank ROM wrap to bank 0
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h2000, 8'h02, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_READ,  16'h4000, 8'h00, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h8000, 8'hFF, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h7FFF, 8'hFF, NO_RESULT},
        '{ROW_CONFIG,  CFG_ROM_SIZE, ROM_CODE_MAX, CMD_READ, 16'h0000, 8'h00, NO_RESULT},
        '{ROW_CONFIG,  CFG_RAM_SIZE, RAM_CODE_FOUR_BANKS, CMD_READ, 16'h0000, 8'h00, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h5FFF, 8'hFF, NO_RESULT},
        // low bits 0 count as 1 with the upper bits on top
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h2000, 8'h00, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h3000, 8'h1F, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_READ,  16'h7FFF, 8'h00, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_READ,  16'hBFFF, 8'h00, NO_RESULT},
        '{ROW_CONFIG,  CFG_ROM_SIZE, 3'd1, CMD_READ, 16'h0000, 8'h00, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_READ,  16'hBFFF, 8'h00, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h1FFF, 8'hFB, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_READ,  16'hA000, 8'h00, NO_RESULT},
        '{ROW_CONFIG,  CFG_RAM_SIZE, RAM_CODE_ONE_BANK, CMD_READ, 16'h0000, 8'h00, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_WRITE, 16'h0100, 8'h5A, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_READ,  16'hBFFF, 8'h00, NO_RESULT},
        '{ROW_CONFIG,  CFG_RAM_SIZE, RAM_CODE_EIGHT_BANKS, CMD_READ, 16'h0000, 8'h00, NO_RESULT},
        '{ROW_CHECKED, CFG_ROM_SIZE, 3'd0, CMD_READ,  16'hA123, 8'h00, NO_RESULT}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  command;
    logic [15:0]           address;
    logic [7:0]            write_data;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            region;
    logic [OFFSET_W-1:0]   physical_offset;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
    logic                  ram_enabled;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CODE_W-1:0]     cfg_data;

    // mapper model state
    logic [CODE_W-1:0]     rom_code_cfg;
    logic [CODE_W-1:0]     ram_code_cfg;
    logic [7:0]            ram_enable_latch;
    logic [LOW_BITS_W-1:0] bank_low;
    logic [1:0]            bank_high;

    result_t pending_results[$];
    int      mismatches;
    bit      quiet;

    cartridge_bank_mapper uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .address         (address),
        .write_data      (write_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .region          (region),
        .physical_offset (physical_offset),
        .rom_bank        (rom_bank),
        .ram_bank        (ram_bank),
        .ram_enabled     (ram_enabled),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Applies one bus access to the model state and returns the translation.
    function automatic result_t translate_access(input logic cmd, input logic [15:0] addr,
                                                 input logic [7:0] data);
        result_t     r;
        int unsigned rom_banks;
        int unsigned ram_banks;
        int unsigned bank;
        logic        large_rom;
        if (cmd == CMD_WRITE)
        begin
            if (addr <= 16'h1FFF)
                ram_enable_latch = data;
            else if (addr <= 16'h3FFF)
                bank_low = data[LOW_BITS_W-1:0];
            else if (addr <= 16'h5FFF)
                bank_high = data[1:0];
            // mode writes latch a bit that never changes the mapping
        end
        large_rom = rom_code_cfg >= ROM_CODE_LARGE;
        rom_banks = 2 << rom_code_cfg;
        case (ram_code_cfg)
            RAM_CODE_ONE_BANK:      ram_banks = 1;
            RAM_CODE_FOUR_BANKS:    ram_banks = 4;
            RAM_CODE_SIXTEEN_BANKS: ram_banks = 16;
            RAM_CODE_EIGHT_BANKS:   ram_banks = 8;
            default:                ram_banks = 0;
        endcase
        bank = (bank_low == '0) ? 1 : int'(bank_low);
        if (large_rom)
            bank = bank + (int'(bank_high) << 5);
        r.rom_bank = ROM_BANK_W'(bank & (rom_banks - 1));
        if (ram_banks == 0 || large_rom)
            r.ram_bank = '0;
        else
            r.ram_bank = RAM_BANK_W'(int'(bank_high) & (ram_banks - 1));
        r.ram_enabled     = ram_enable_latch[3:0] == RAM_ENABLE_KEY;
        r.region          = REGION_NONE;
        r.physical_offset = '0;
        if (cmd == CMD_READ)
        begin
            if (addr <= 16'h3FFF)
            begin
                r.region          = REGION_FIXED_ROM;
                r.physical_offset = OFFSET_W'(addr);
            end
            else if (addr <= 16'h7FFF)
            begin
                r.region          = REGION_SWITCHED_ROM;
                r.physical_offset = OFFSET_W'(int'(r.rom_bank) * ROM_BANK_BYTES
                                              + int'(addr) - 'h4000);
            end
            else if (addr >= 16'hA000 && addr <= 16'hBFFF && r.ram_enabled && ram_banks != 0)
            begin
                r.region          = REGION_RAM;
                r.physical_offset = OFFSET_W'(int'(r.ram_bank) * RAM_BANK_BYTES
                                              + int'(addr) - 'hA000);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
            report_mismatch("result word with none pending", 0, region);
        else
        begin
            want = pending_results.pop_front();
            if (region !== want.region)
                report_mismatch("region", want.region, region);
            if (physical_offset !== want.physical_offset)
                report_mismatch("physical_offset", want.physical_offset, physical_offset);
            if (rom_bank !== want.rom_bank)
                report_mismatch("rom_bank", want.rom_bank, rom_bank);
            if (ram_bank !== want.ram_bank)
                report_mismatch("ram_bank", want.ram_bank, ram_bank);
            if (ram_enabled !== want.ram_enabled)
                report_mismatch("ram_enabled", want.ram_enabled, ram_enabled);
        end
    endtask

    task automatic send_access(input logic cmd, input logic [15:0] addr, input logic [7:0] data,
                               input logic typed, input result_t typed_result);
        int      gap;
        result_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 3);
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
        @(negedge clk);
        in_valid   <= 1'b1;
        command    <= cmd;
        address    <= addr;
        write_data <= data;
        do @(posedge clk); while (!(in_valid && in_ready));
        predicted = translate_access(cmd, addr, data);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_idle();
        @(negedge clk) in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // result register and input register both empty by now
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk) cfg_write <= 1'b0;
        if (idx == CFG_ROM_SIZE)
            rom_code_cfg = val;
        else
            ram_code_cfg = val;
    endtask

    task automatic random_access(output logic cmd, output logic [15:0] addr,
                                 output logic [7:0] data);
        int pick;
        pick = $urandom_range(0, 99);
        data = 8'($urandom_range(0, 255));
        if (pick < 30)
        begin
            cmd  = CMD_WRITE;
            addr = 16'($urandom_range(0, 'h7FFF));
            // bias enable writes toward the key nibble
            if (addr <= 16'h1FFF && $urandom_range(0, 1) == 1)
                data[3:0] = RAM_ENABLE_KEY;
        end
        else if (pick < 36)
        begin
            cmd  = CMD_WRITE;
            addr = 16'($urandom_range('h8000, 'hFFFF));
        end
        else if (pick < 60)
        begin
            cmd  = CMD_READ;
            addr = 16'($urandom_range(0, 'h7FFF));
        end
        else if (pick < 85)
        begin
            cmd  = CMD_READ;
            addr = 16'($urandom_range('hA000, 'hBFFF));
        end
        else
        begin
            cmd  = CMD_READ;
            addr = 16'($urandom_range(0, 'hFFFF));
        end
        // every range is 8K aligned, so this hits its edges without leaving it
        if ($urandom_range(0, 7) == 0)
            addr[12:0] = ($urandom_range(0, 1) == 1) ? '1 : '0;
    endtask

    // result side
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            repeat (stall) @(negedge clk) out_ready <= 1'b0;
            @(negedge clk) out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            check_result();
        end
    end

    // access side
    initial
    begin
        logic              cmd;
        logic [15:0]       addr;
        logic [7:0]        data;
        logic [CODE_W-1:0] rom_pick;
        logic [CODE_W-1:0] ram_pick;
        int                waited;
        in_valid         = 1'b0;
        command          = CMD_WRITE;
        address          = '0;
        write_data       = '0;
        cfg_write        = 1'b0;
        cfg_index        = CFG_ROM_SIZE;
        cfg_data         = '0;
        rst_n            = 1'b0;
        quiet            = 1'b0;
        mismatches       = 0;
        rom_code_cfg     = '0;
        ram_code_cfg     = '0;
        ram_enable_latch = '0;
        bank_low         = '0;
        bank_high        = '0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CONFIG)
            begin
                wait_idle();
                write_register(DIRECTED[i].reg_index, DIRECTED[i].reg_value);
            end
            else
                send_access(DIRECTED[i].cmd, DIRECTED[i].addr, DIRECTED[i].data,
                            DIRECTED[i].kind == ROW_TYPED, DIRECTED[i].want);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    rom_pick = ROM_CODE_MAX;
                    ram_pick = RAM_CODE_MAX;
                end
                1:
                begin
                    rom_pick = ROM_CODE_MIN;
                    ram_pick = RAM_CODE_NONE;
                end
                2:
                begin
                    rom_pick = ROM_CODE_LARGE;
                    ram_pick = RAM_CODE_SIXTEEN_BANKS;
                end
                default:
                begin
                    rom_pick = CODE_W'($urandom_range(0, ROM_CODE_MAX));
                    ram_pick = CODE_W'($urandom_range(0, RAM_CODE_MAX));
                end
            endcase
            wait_idle();
            write_register(CFG_ROM_SIZE, rom_pick);
            write_register(CFG_RAM_SIZE, ram_pick);
            quiet = (phase % 4 == 3);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                random_access(cmd, addr, data);
                send_access(cmd, addr, data, 1'b0, NO_RESULT);
            end
        end

        quiet = 1'b0;
        @(negedge clk) in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
            report_mismatch("result words never delivered", 0, pending_results.size());
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cbm_pkg.sv
rtl/cbm_ctrl.sv
rtl/cbm_xlate.sv
rtl/cartridge_bank_mapper.sv
tb/testbench.sv
